FILE: hw/rtl/assert_macros.svh
// Assertion helpers; clk_i and rst_ni are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CRT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CRT_ASSERT(lbl, prop, msg)
`define CRT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hw/rtl/crt_pkg.sv
package crt_pkg;

  localparam int TableDepth = 8;
  localparam int IdxW   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW   = $clog2(TableDepth + 1);
  localparam int CoordW = 16;
  localparam int KeyW   = 3 * CoordW;
  localparam int LimW   = 4;
  localparam int OccW   = 4;
  localparam int StatW  = 3;
  localparam int PaddrW = 3;
  localparam int DataW  = 32;

  localparam logic [LimW-1:0] LimReset = 4'd8;
  localparam logic RegEntryLimit = 1'b0;

  typedef enum logic {
    ModeRequest  = 1'b0,
    ModeComplete = 1'b1
  } mode_e;

  typedef enum logic [StatW-1:0] {
    StFull     = 3'd0,
    StPending  = 3'd1,
    StAccepted = 3'd2,
    StRemoved  = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SCmp,
    SMoveRd,
    SMoveWr,
    SResp
  } state_e;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [KeyW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hw/rtl/crt_if.sv
interface crt_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic signed [crt_pkg::CoordW-1:0]  coord_x;
  logic signed [crt_pkg::CoordW-1:0]  coord_y;
  logic signed [crt_pkg::CoordW-1:0]  coord_z;

  modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface crt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [crt_pkg::StatW-1:0]  status;
  logic [crt_pkg::OccW-1:0]   occupancy;

  modport source (output valid, status, occupancy, input ready);
  modport sink   (input valid, status, occupancy, output ready);
endinterface

FILE: hw/rtl/crt_table.sv
module crt_table (
  input  logic                      clk_i,
  input  crt_pkg::mem_req_t         mem_req_i,
  output logic [crt_pkg::KeyW-1:0]  rdata_o
);

  logic [crt_pkg::KeyW-1:0] mem [crt_pkg::TableDepth];
  logic [crt_pkg::KeyW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rdata_q <= mem[mem_req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/crt_seq.sv
module crt_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [crt_pkg::LimW-1:0]  limit_i,
  crt_req_if.sink                   req_i,
  crt_rsp_if.source                 rsp_o,
  output crt_pkg::mem_req_t         mem_req_o,
  input  logic [crt_pkg::KeyW-1:0]  rdata_i,
  output logic [crt_pkg::CntW-1:0]  count_o
);

  crt_pkg::state_e           st_q, st_d;
  logic [crt_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [crt_pkg::IdxW-1:0]  slot_q, slot_d;
  logic [crt_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      mode_q, mode_d;
  logic [crt_pkg::KeyW-1:0]  key_q, key_d;
  crt_pkg::status_e          status_q, status_d;

  logic [crt_pkg::CntW-1:0]  lim_eff;
  logic [crt_pkg::KeyW-1:0]  in_key;
  logic                      match;
  logic                      last;

  assign lim_eff = (32'(limit_i) > 32'(crt_pkg::TableDepth)) ?
                   crt_pkg::CntW'(crt_pkg::TableDepth) : crt_pkg::CntW'(limit_i);
  assign in_key  = {req_i.coord_z, req_i.coord_y, req_i.coord_x};
  assign match   = (rdata_i == key_q);
  assign last    = (crt_pkg::CntW'(idx_q) == cnt_q - crt_pkg::CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= crt_pkg::SIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    mode_q   <= mode_d;
    key_q    <= key_d;
    status_q <= status_d;
  end

  always_comb begin
    st_d            = st_q;
    idx_d           = idx_q;
    slot_d          = slot_q;
    cnt_d           = cnt_q;
    mode_d          = mode_q;
    key_d           = key_q;
    status_d        = status_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = crt_pkg::IdxW'(cnt_q);
    mem_req_o.wdata = key_q;
    mem_req_o.raddr = idx_q;
    req_i.ready     = 1'b0;
    rsp_o.valid     = 1'b0;

    unique case (st_q)
      crt_pkg::SIdle: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          mode_d = req_i.mode;
          key_d  = in_key;
          idx_d  = '0;
          if (req_i.mode == crt_pkg::ModeRequest) begin
            if (cnt_q >= lim_eff) begin
              status_d = crt_pkg::StFull;
              st_d     = crt_pkg::SResp;
            end else if (cnt_q == '0) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.wdata = in_key;
              cnt_d           = cnt_q + crt_pkg::CntW'(1);
              status_d        = crt_pkg::StAccepted;
              st_d            = crt_pkg::SResp;
            end else begin
              st_d = crt_pkg::SRead;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = crt_pkg::StNotFound;
              st_d     = crt_pkg::SResp;
            end else begin
              st_d = crt_pkg::SRead;
            end
          end
        end
      end
      crt_pkg::SRead: begin
        st_d = crt_pkg::SCmp;
      end
      crt_pkg::SCmp: begin
        if (match) begin
          if (mode_q == crt_pkg::ModeRequest) begin
            status_d = crt_pkg::StPending;
            st_d     = crt_pkg::SResp;
          end else begin
            slot_d = idx_q;
            st_d   = crt_pkg::SMoveRd;
          end
        end else if (last) begin
          if (mode_q == crt_pkg::ModeRequest) begin
            mem_req_o.we = 1'b1;
            cnt_d        = cnt_q + crt_pkg::CntW'(1);
            status_d     = crt_pkg::StAccepted;
          end else begin
            status_d = crt_pkg::StNotFound;
          end
          st_d = crt_pkg::SResp;
        end else begin
          idx_d = idx_q + crt_pkg::IdxW'(1);
          st_d  = crt_pkg::SRead;
        end
      end
      crt_pkg::SMoveRd: begin
        mem_req_o.raddr = crt_pkg::IdxW'(cnt_q - crt_pkg::CntW'(1));
        st_d            = crt_pkg::SMoveWr;
      end
      crt_pkg::SMoveWr: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = slot_q;
        mem_req_o.wdata = rdata_i;
        cnt_d           = cnt_q - crt_pkg::CntW'(1);
        status_d        = crt_pkg::StRemoved;
        st_d            = crt_pkg::SResp;
      end
      crt_pkg::SResp: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) begin
          st_d = crt_pkg::SIdle;
        end
      end
      default: begin
        st_d = crt_pkg::SIdle;
      end
    endcase
  end

  assign rsp_o.status    = status_q;
  assign rsp_o.occupancy = crt_pkg::OccW'(cnt_q);
  assign count_o         = cnt_q;

endmodule

FILE: hw/rtl/chunk_request_tracker.sv
// A word is answered directly when the table is empty, or full for a request; otherwise the
// stored entries are scanned one by one (read, then compare), and on removal the last entry
// is read and written into the freed slot. A new word is taken only after the previous
// response has been accepted; the scan runs through the single table read port feeding one
// shared key comparator.
// Reset clears the entry count, the sequencer and sets entry_limit to 8; table contents
// are not cleared.
`include "assert_macros.svh"

module chunk_request_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [crt_pkg::PaddrW-1:0]  paddr_i,
  input  logic [crt_pkg::DataW-1:0]   pwdata_i,
  output logic [crt_pkg::DataW-1:0]   prdata_o,
  output logic                        pready_o,
  crt_req_if.sink                     req_i,
  crt_rsp_if.source                   rsp_o
);

  logic [crt_pkg::LimW-1:0]  limit_q;
  crt_pkg::mem_req_t         mem_req;
  logic [crt_pkg::KeyW-1:0]  rdata;
  logic [crt_pkg::CntW-1:0]  count;
  logic                      reg_sel;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[2] == crt_pkg::RegEntryLimit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= crt_pkg::LimReset;
    end else if (psel_i && penable_i && pwrite_i && reg_sel) begin
      limit_q <= pwdata_i[crt_pkg::LimW-1:0];
    end
  end

  assign prdata_o = reg_sel ? crt_pkg::DataW'(limit_q) : '0;

  crt_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .limit_i   (limit_q),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rdata_i   (rdata),
    .count_o   (count)
  );

  crt_table u_table (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

  `CRT_NEVER(a_count_range, (32'(count) > 32'(crt_pkg::TableDepth)), "count above depth")
  `CRT_NEVER(a_busy_excl, (req_i.ready && rsp_o.valid), "ready while result pending")
  `CRT_ASSERT(a_busy_after_take, (req_i.valid && req_i.ready |=> !req_i.ready), "not busy")

endmodule
